// ===== hdl/sfd_pkg.sv =====
`timescale 1ns / 1ps
// sfd_pkg: widths, word types, register codes and reset values for the
// sierpinski fold distance pipeline. depends on nothing.
package sfd_pkg;

    localparam int CW        = 32;
    localparam int FRAC      = CW - 8;
    localparam int RW        = 2 * CW;
    localparam int REM_W     = CW + 2;
    localparam int CNT_W     = 4;
    localparam int LIMIT_W   = 4;
    localparam int BAIL_W    = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    typedef logic signed [CW-1:0] coord_t;

    localparam coord_t COORD_MAX = coord_t'({1'b0, {(CW-1){1'b1}}});
    localparam coord_t COORD_MIN = coord_t'({1'b1, {(CW-1){1'b0}}});
    localparam logic [CW+1:0] SCALE_ONE   = (CW+2)'(1) << FRAC;
    localparam logic [CW+1:0] DIST_OFFSET = (CW+2)'(2) << FRAC;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd10;
    localparam logic [BAIL_W-1:0]  BAIL_RST  = 11'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ITER_LIMIT = 1'b0,
        CFG_BAILOUT    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        coord_t           x;
        coord_t           y;
        coord_t           z;
        logic [RW-1:0]    r;
        logic [CNT_W-1:0] n;
    } point_t;

    typedef struct packed {
        logic [CNT_W-1:0] limit;
        logic [RW-1:0]    bail;
    } fold_cfg_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] distance;
        logic [3:0]         iterations_used;
    } out_word_t;

endpackage

// ===== hdl/sfd_stream_if.sv =====
`timescale 1ns / 1ps
// sfd_stream_if: valid/ready channel carrying one word of a given type.
// depends on nothing; word types come from sfd_pkg at the instance.
interface sfd_stream_if #(
    parameter type word_t = logic
) ();
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sfd_radius.sv =====
`timescale 1ns / 1ps
// sfd_radius: two-stage squared radius, three squares then their sum.
// depends on sfd_pkg.
module sfd_radius
    import sfd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   in_valid,
    input  point_t in_pt,
    output logic   out_valid,
    output point_t out_pt
);

    logic [CW-1:0] mag_x;
    logic [CW-1:0] mag_y;
    logic [CW-1:0] mag_z;
    logic [RW-1:0] sq_x_next;
    logic [RW-1:0] sq_y_next;
    logic [RW-1:0] sq_z_next;
    logic [RW-1:0] sq_x_reg;
    logic [RW-1:0] sq_y_reg;
    logic [RW-1:0] sq_z_reg;
    point_t        p1_reg;
    point_t        p2_next;
    point_t        p2_reg;
    logic          v1_reg;
    logic          v2_reg;

    // magnitude of the most negative value wraps to the right unsigned value
    assign mag_x = in_pt.x[CW-1] ? CW'(-in_pt.x) : CW'(in_pt.x);
    assign mag_y = in_pt.y[CW-1] ? CW'(-in_pt.y) : CW'(in_pt.y);
    assign mag_z = in_pt.z[CW-1] ? CW'(-in_pt.z) : CW'(in_pt.z);

    assign sq_x_next = mag_x * mag_x;
    assign sq_y_next = mag_y * mag_y;
    assign sq_z_next = mag_z * mag_z;

    always_comb
    begin
        p2_next   = p1_reg;
        p2_next.r = sq_x_reg + sq_y_reg + sq_z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_x_reg <= sq_x_next;
            sq_y_reg <= sq_y_next;
            sq_z_reg <= sq_z_next;
            p1_reg   <= in_pt;
            p2_reg   <= p2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_pt    = p2_reg;

endmodule

// ===== hdl/sfd_fold.sv =====
`timescale 1ns / 1ps
// sfd_fold: one iteration's escape test, three folds and the scale step,
// over three register stages. depends on sfd_pkg.
module sfd_fold
    import sfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  fold_cfg_t cfg,
    input  logic      in_valid,
    input  point_t    in_pt,
    output logic      out_valid,
    output point_t    out_pt
);

    function automatic coord_t neg_sat(input coord_t v);
        return (v == COORD_MIN) ? COORD_MAX : coord_t'(-v);
    endfunction

    function automatic logic sum_neg(input coord_t a, input coord_t b);
        logic [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        return s[CW];
    endfunction

    function automatic coord_t scale(input coord_t c);
        logic [CW+1:0] t;
        t = {c[CW-1], c, 1'b0} - SCALE_ONE;
        if (!t[CW+1] && (t[CW:CW-1] != 2'b00))
            return COORD_MAX;
        else if (t[CW+1] && (t[CW:CW-1] != 2'b11))
            return COORD_MIN;
        else
            return coord_t'(t[CW-1:0]);
    endfunction

    logic   act0;
    point_t s0_next;
    point_t s0_reg;
    point_t s1_next;
    point_t s1_reg;
    point_t s2_next;
    point_t s2_reg;
    logic   act0_reg;
    logic   act1_reg;
    logic   v0_reg;
    logic   v1_reg;
    logic   v2_reg;

    assign act0 = (in_pt.n < cfg.limit) && (in_pt.r < cfg.bail);

    // escape test and x/y fold
    always_comb
    begin
        s0_next = in_pt;
        if (act0)
        begin
            s0_next.n = in_pt.n + 1'b1;
            if (sum_neg(in_pt.x, in_pt.y))
            begin
                s0_next.x = neg_sat(in_pt.y);
                s0_next.y = neg_sat(in_pt.x);
            end
        end
    end

    // x/z fold
    always_comb
    begin
        s1_next = s0_reg;
        if (act0_reg && sum_neg(s0_reg.x, s0_reg.z))
        begin
            s1_next.x = neg_sat(s0_reg.z);
            s1_next.z = neg_sat(s0_reg.x);
        end
    end

    // y/z fold then 2c - 1
    always_comb
    begin
        coord_t fy;
        coord_t fz;
        s2_next = s1_reg;
        fy      = s1_reg.y;
        fz      = s1_reg.z;
        if (sum_neg(s1_reg.y, s1_reg.z))
        begin
            fy = neg_sat(s1_reg.z);
            fz = neg_sat(s1_reg.y);
        end
        if (act1_reg)
        begin
            s2_next.x = scale(s1_reg.x);
            s2_next.y = scale(fy);
            s2_next.z = scale(fz);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg   <= s0_next;
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            act0_reg <= act0;
            act1_reg <= act0_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_pt    = s2_reg;

endmodule

// ===== hdl/sfd_isqrt.sv =====
`timescale 1ns / 1ps
// sfd_isqrt: pipelined integer square root, one result bit per stage,
// carrying the iteration count alongside. depends on sfd_pkg.
module sfd_isqrt
    import sfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [RW-1:0]    in_rad,
    input  logic [CNT_W-1:0] in_n,
    output logic             out_valid,
    output logic [CW-1:0]    out_root,
    output logic [CNT_W-1:0] out_n
);

    logic [REM_W-1:0] rem_reg  [CW];
    logic [CW-1:0]    root_reg [CW];
    logic [RW-1:0]    rad_reg  [CW];
    logic [CNT_W-1:0] n_reg    [CW];
    logic             vld_reg  [CW];

    for (genvar k = 0; k < CW; k++)
    begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [CW-1:0]    root_in;
        logic [RW-1:0]    rad_in;
        logic [CNT_W-1:0] n_in;
        logic             vld_in;
        logic [REM_W+1:0] acc;
        logic [REM_W+1:0] trial;
        logic             fit;
        logic [REM_W-1:0] rem_next;
        logic [CW-1:0]    root_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign n_in    = in_n;
            assign vld_in  = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign n_in    = n_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        always_comb
        begin
            acc       = {rem_in, rad_in[2*(CW-1-k)+1 -: 2]};
            trial     = {2'b00, root_in, 2'b01};
            fit       = (acc >= trial);
            rem_next  = fit ? REM_W'(acc - trial) : acc[REM_W-1:0];
            root_next = {root_in[CW-2:0], fit};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_in;
                n_reg[k]    <= n_in;
            end
        end
    end

    assign out_valid = vld_reg[CW-1];
    assign out_root  = root_reg[CW-1];
    assign out_n     = n_reg[CW-1];

endmodule

// ===== hdl/sierpinski_fold_distance.sv =====
`timescale 1ns / 1ps
// sierpinski_fold_distance: top level, config registers, iteration chain,
// square root and output stage. depends on sfd_pkg, sfd_stream_if and submodules.
//
//  port    | dir  | word        | contents
//  point   | sink | in_word_t   | pos_x, pos_y, pos_z, signed q8.24
//  result  | src  | out_word_t  | distance q8.24, iterations_used
//  cfg_*   | in   | 11-bit data | iteration_limit, bailout_radius_sq
//
// one word enters per cycle while the pipeline is not held; each word passes
// the input radius, the unrolled iterations and the bitwise root, then the output stage
// one global advance: every stage holds while the result register is full
// and not taken, so point.ready follows result.ready
// reset clears valid bits and loads the register defaults
module sierpinski_fold_distance
    import sfd_pkg::*;
#(
    parameter int MAX_ITERATIONS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sfd_stream_if.sink           point,
    sfd_stream_if.source         result
);

    logic [LIMIT_W-1:0]     limit_reg;
    logic [BAIL_W-1:0]      bail_reg;
    fold_cfg_t              fcfg;
    logic                   adv;

    point_t                 pt_chain  [MAX_ITERATIONS+1];
    logic                   vld_chain [MAX_ITERATIONS+1];
    point_t                 in_pt;

    logic                   isq_valid;
    logic [CW-1:0]          isq_root;
    logic [CNT_W-1:0]       isq_n;

    logic signed [CW+1:0]   d_next;
    logic signed [CW+1:0]   d_reg;
    logic [CNT_W-1:0]       na_reg;
    logic                   va_reg;

    logic signed [CW+1:0]   sh;
    coord_t                 dist_next;
    coord_t                 distance_reg;
    logic [CNT_W-1:0]       iter_reg;
    logic                   result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RST;
            bail_reg  <= BAIL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ITER_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_BAILOUT:    bail_reg  <= cfg_data[BAIL_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        fcfg.limit = (int'(limit_reg) > MAX_ITERATIONS) ? CNT_W'(MAX_ITERATIONS)
                                                        : CNT_W'(limit_reg);
        fcfg.bail  = RW'(bail_reg) << (2 * FRAC);
    end

    assign adv         = !result_valid_reg || result.ready;
    assign point.ready = adv;

    always_comb
    begin
        in_pt.x = coord_t'(point.data.pos_x);
        in_pt.y = coord_t'(point.data.pos_y);
        in_pt.z = coord_t'(point.data.pos_z);
        in_pt.r = '0;
        in_pt.n = '0;
    end

    sfd_radius u_rad_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (point.valid),
        .in_pt     (in_pt),
        .out_valid (vld_chain[0]),
        .out_pt    (pt_chain[0])
    );

    for (genvar i = 0; i < MAX_ITERATIONS; i++)
    begin : g_iter
        logic   fold_valid;
        point_t fold_pt;

        sfd_fold u_fold (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .cfg       (fcfg),
            .in_valid  (vld_chain[i]),
            .in_pt     (pt_chain[i]),
            .out_valid (fold_valid),
            .out_pt    (fold_pt)
        );

        sfd_radius u_rad (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (fold_valid),
            .in_pt     (fold_pt),
            .out_valid (vld_chain[i+1]),
            .out_pt    (pt_chain[i+1])
        );
    end

    sfd_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (vld_chain[MAX_ITERATIONS]),
        .in_rad    (pt_chain[MAX_ITERATIONS].r),
        .in_n      (pt_chain[MAX_ITERATIONS].n),
        .out_valid (isq_valid),
        .out_root  (isq_root),
        .out_n     (isq_n)
    );

    assign d_next = $signed({2'b00, isq_root} - DIST_OFFSET);

    always_comb
    begin
        sh = d_reg >>> na_reg;
        if (!sh[CW+1] && (sh[CW+1:CW-1] != 3'b000))
            dist_next = COORD_MAX;
        else if (sh[CW+1] && (sh[CW+1:CW-1] != 3'b111))
            dist_next = COORD_MIN;
        else
            dist_next = coord_t'(sh[CW-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg           <= isq_valid;
            result_valid_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg        <= d_next;
            na_reg       <= isq_n;
            distance_reg <= dist_next;
            iter_reg     <= na_reg;
        end
    end

    assign result.valid                = result_valid_reg;
    assign result.data.distance        = distance_reg;
    assign result.data.iterations_used = iter_reg;

    // a held pipeline keeps every tracked valid bit
    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_chain[0]) && $stable(isq_valid) && $stable(va_reg))
        else $error("pipeline moved while held");

    // a taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && !va_reg |=> !result.valid)
        else $error("result repeated after drain");

    // the count never passes the unrolled depth
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (int'(result.data.iterations_used) <= MAX_ITERATIONS))
        else $error("iteration count beyond depth");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives points into sierpinski_fold_distance and checks each result word
// against its own fold, scale and root predictor across register settings and stalls.
// depends on sfd_pkg, sfd_stream_if and the rtl top level.
module testbench
    import sfd_pkg::*;
();

    localparam longint      Q_ONE       = 64'sd1 << FRAC;
    localparam longint      SAT_HI      = 64'sd2147483647;
    localparam longint      SAT_LO      = -64'sd2147483648;
    localparam int          MAX_ITER    = 10;
    localparam int          LATENCY     = 2 + 5 * MAX_ITER + 32 + 2;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam coord_t      ONE_Q       = 32'sh0100_0000;
    localparam coord_t      HALF_Q      = 32'sh0080_0000;
    localparam coord_t      QUARTER_Q   = 32'sh0040_0000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    sfd_stream_if #(.word_t(in_word_t))  point_if ();
    sfd_stream_if #(.word_t(out_word_t)) result_if ();

    logic [LIMIT_W-1:0] limit_setting;
    logic [BAIL_W-1:0]  bail_setting;
    out_word_t          predicted_words [$];
    int unsigned        mismatch_count;
    int unsigned        cycle_count;
    int unsigned        hold_cycles;
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;

    sierpinski_fold_distance u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point     (point_if),
        .result    (result_if)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint clamp_coord(longint v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    function automatic void fold_pair(inout longint a, inout longint b);
        longint old_a;
        old_a = a;
        if (a + b < 0)
        begin
            a = clamp_coord(-b);
            b = clamp_coord(-old_a);
        end
    endfunction

    function automatic logic [65:0] radius_sq(longint x, longint y, longint z);
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] sz;
        sx = x * x;
        sy = y * y;
        sz = z * z;
        return {2'b00, sx} + {2'b00, sy} + {2'b00, sz};
    endfunction

    function automatic logic [32:0] root_floor(logic [65:0] r);
        logic [32:0] root;
        logic [32:0] trial;
        root = '0;
        for (int b = 32; b >= 0; b--)
        begin
            trial = root | (33'd1 << b);
            if ({33'd0, trial} * {33'd0, trial} <= r)
                root = trial;
        end
        return root;
    endfunction

    function automatic out_word_t fold_distance_estimate(in_word_t w,
                                                         logic [LIMIT_W-1:0] lim_reg,
                                                         logic [BAIL_W-1:0] bail_reg);
        longint      x;
        longint      y;
        longint      z;
        longint      d;
        logic [65:0] r;
        logic [65:0] bail;
        int unsigned lim;
        int unsigned n;
        out_word_t   o;
        x = longint'($signed(w.pos_x));
        y = longint'($signed(w.pos_y));
        z = longint'($signed(w.pos_z));
        lim = (lim_reg > MAX_ITER) ? MAX_ITER : lim_reg;
        bail = {55'd0, bail_reg} << (2 * FRAC);
        r = radius_sq(x, y, z);
        n = 0;
        while (n < lim && r < bail)
        begin
            fold_pair(x, y);
            fold_pair(x, z);
            fold_pair(y, z);
            x = clamp_coord(2 * x - Q_ONE);
            y = clamp_coord(2 * y - Q_ONE);
            z = clamp_coord(2 * z - Q_ONE);
            r = radius_sq(x, y, z);
            n++;
        end
        d = longint'({31'd0, root_floor(r)}) - 2 * Q_ONE;
        d = clamp_coord(d >>> n);
        o.distance        = d[31:0];
        o.iterations_used = n[3:0];
        return o;
    endfunction

    function automatic in_word_t point_of(coord_t x, coord_t y, coord_t z);
        in_word_t w;
        w.pos_x = x;
        w.pos_y = y;
        w.pos_z = z;
        return w;
    endfunction

    function automatic coord_t random_coord(int unsigned span);
        if (span == 0)
            return coord_t'($urandom);
        return coord_t'($urandom_range(2 * span) - span);
    endfunction

    function automatic in_word_t random_point();
        int unsigned kind;
        int unsigned span;
        kind = $urandom_range(9);
        if (kind < 2)
            span = 0;
        else if (kind < 4)
            span = 12 << FRAC;
        else
            span = 2 << FRAC;
        return point_of(random_coord(span), random_coord(span), random_coord(span));
    endfunction

    // result words are checked before the accepted point is predicted
    always @(posedge clk)
    begin
        out_word_t want;
        if (result_if.valid && result_if.ready)
        begin
            if (predicted_words.size() == 0)
            begin
                $display("%0t unexpected word: distance %h iterations %0d", $time,
                         result_if.data.distance, result_if.data.iterations_used);
                mismatch_count++;
            end
            else
            begin
                want = predicted_words.pop_front();
                if (result_if.data.distance !== want.distance)
                begin
                    $display("%0t distance expected %h got %h", $time,
                             want.distance, result_if.data.distance);
                    mismatch_count++;
                end
                if (result_if.data.iterations_used !== want.iterations_used)
                begin
                    $display("%0t iterations_used expected %0d got %0d", $time,
                             want.iterations_used, result_if.data.iterations_used);
                    mismatch_count++;
                end
            end
        end
        if (point_if.valid && point_if.ready)
            predicted_words.push_back(fold_distance_estimate(point_if.data,
                                                             limit_setting, bail_setting));
    end

    always @(posedge clk)
    begin
        if (hold_cycles != 0)
        begin
            result_if.ready <= 1'b0;
            hold_cycles     <= hold_cycles - 1;
        end
        else
            result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_point(input in_word_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            point_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        point_if.valid <= 1'b1;
        point_if.data  <= w;
        @(posedge clk);
        while (!point_if.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        point_if.valid <= 1'b0;
        @(posedge clk);
        while (predicted_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_config(input logic [LIMIT_W-1:0] lim, input logic [BAIL_W-1:0] bail);
        wait_idle();
        @(posedge clk);
        cfg_we        <= 1'b1;
        cfg_index     <= CFG_ITER_LIMIT;
        cfg_data      <= CFG_W'(lim);
        limit_setting <= lim;
        @(posedge clk);
        cfg_index     <= CFG_BAILOUT;
        cfg_data      <= bail;
        bail_setting  <= bail;
        @(posedge clk);
        cfg_we        <= 1'b0;
    endtask

    task automatic test_corner_points();
        send_point(point_of(0, 0, 0));
        send_point(point_of(ONE_Q, ONE_Q, ONE_Q));
        send_point(point_of(-ONE_Q, -ONE_Q, ONE_Q));
        send_point(point_of(-HALF_Q, QUARTER_Q, 3 * QUARTER_Q));
        send_point(point_of(ONE_Q, -HALF_Q, -QUARTER_Q));
        send_point(point_of(HALF_Q, -HALF_Q, -HALF_Q));
        send_point(point_of(10 * ONE_Q, 0, 0));
        send_point(point_of(10 * ONE_Q - 1, 0, 0));
        send_point(point_of(COORD_MAX, COORD_MAX, COORD_MAX));
        send_point(point_of(COORD_MIN, COORD_MIN, COORD_MIN));
        send_point(point_of(COORD_MAX, COORD_MIN, 0));
        send_point(point_of(-1, -1, -1));
        wait_idle();
    endtask

    task automatic test_register_extremes();
        logic [LIMIT_W-1:0] lims  [4];
        logic [BAIL_W-1:0]  bails [4];
        lims  = '{4'd0, 4'd15, 4'd1, 4'd10};
        bails = '{11'd100, 11'd2047, 11'd0, 11'd1};
        for (int i = 0; i < 4; i++)
        begin
            apply_config(lims[i], bails[i]);
            send_point(point_of(0, 0, 0));
            send_point(point_of(-HALF_Q, QUARTER_Q, ONE_Q));
            send_point(point_of(COORD_MIN, COORD_MIN, COORD_MIN));
        end
        wait_idle();
    endtask

    task automatic test_random_traffic(input int count, input logic [LIMIT_W-1:0] lim,
                                       input logic [BAIL_W-1:0] bail,
                                       input int unsigned send_pct,
                                       input int unsigned recv_pct);
        apply_config(lim, bail);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
            send_point(random_point());
        wait_idle();
    endtask

    // long receiver hold-off so the pipeline fills and backs up into the input
    task automatic test_output_backpressure();
        apply_config(LIMIT_RST, BAIL_RST);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles   <= 400;
        for (int i = 0; i < 120; i++)
            send_point(random_point());
        wait_idle();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_ITER_LIMIT;
        cfg_data        = '0;
        point_if.valid  = 1'b0;
        point_if.data   = '0;
        result_if.ready = 1'b0;
        limit_setting   = LIMIT_RST;
        bail_setting    = BAIL_RST;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_cycles     = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_corner_points();
        test_register_extremes();
        test_random_traffic(80, 4'd10, 11'd100, 0, 0);
        test_random_traffic(80, 4'd7, 11'd1024, 67, 0);
        test_random_traffic(80, LIMIT_W'($urandom_range(15)), BAIL_W'($urandom_range(2047)),
                            0, 67);
        test_random_traffic(80, 4'd10, 11'd2047, 10, 10);
        test_output_backpressure();

        repeat (LATENCY + 14) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sfd_pkg.sv
hdl/sfd_stream_if.sv
hdl/sfd_radius.sv
hdl/sfd_fold.sv
hdl/sfd_isqrt.sv
hdl/sierpinski_fold_distance.sv
verif/testbench.sv
